// ----- rtl/assert_macros.svh -----
// assertion macros for the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion sampled on the clock, muted while reset is asserted
`define CTFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion sampled on the clock, active during reset as well
`define CTFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ctfp_pkg.sv -----
// types and constants of the charger text field parser
package ctfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned OutW   = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned QDepth = 2;

  localparam logic [ByteW-1:0] CharCr    = 8'h0D;
  localparam logic [ByteW-1:0] CharLf    = 8'h0A;
  localparam logic [ByteW-1:0] CharTab   = 8'h09;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [ByteW-1:0] CharVt    = 8'h0B;
  localparam logic [ByteW-1:0] CharFf    = 8'h0C;
  localparam logic [ByteW-1:0] CharPlus  = 8'h2B;
  localparam logic [ByteW-1:0] CharMinus = 8'h2D;
  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharNine  = 8'h39;
  localparam logic [ByteW-1:0] CharP     = 8'h50;
  localparam logic [ByteW-1:0] CharV     = 8'h56;
  localparam logic [ByteW-1:0] CharE     = 8'h45;
  localparam logic [ByteW-1:0] CharR     = 8'h52;
  localparam logic [ByteW-1:0] CharC     = 8'h43;
  localparam logic [ByteW-1:0] CharS     = 8'h53;

  localparam logic [KindW-1:0] KindPower   = 2'd0;
  localparam logic [KindW-1:0] KindVoltage = 2'd1;
  localparam logic [KindW-1:0] KindError   = 2'd2;
  localparam logic [KindW-1:0] KindState   = 2'd3;

  typedef enum logic [2:0] {
    CLS_CR,
    CLS_LF,
    CLS_TAB,
    CLS_SPACE,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_OTHER
  } char_class_e;

  // one classified byte on its way from the front to the back
  typedef struct packed {
    logic [ByteW-1:0] data;
    char_class_e      cls;
    logic             last;
  } front_item_t;

endpackage

// ----- rtl/ctfp_front.sv -----
// front end: accepts bytes, classifies them and queues them for the back end
module ctfp_front
  import ctfp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ByteW-1:0]     in_data_i,
  input  logic                 in_last_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output front_item_t          q_item_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  front_item_t         mem_q [QDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop;
  front_item_t         item_new;

  always_comb begin
    item_new.data = in_data_i;
    item_new.last = in_last_i;
    if (in_data_i == CharCr) begin
      item_new.cls = CLS_CR;
    end else if (in_data_i == CharLf) begin
      item_new.cls = CLS_LF;
    end else if (in_data_i == CharTab) begin
      item_new.cls = CLS_TAB;
    end else if (in_data_i inside {CharSpace, CharVt, CharFf}) begin
      item_new.cls = CLS_SPACE;
    end else if (in_data_i == CharPlus) begin
      item_new.cls = CLS_PLUS;
    end else if (in_data_i == CharMinus) begin
      item_new.cls = CLS_MINUS;
    end else if (in_data_i inside {[CharZero:CharNine]}) begin
      item_new.cls = CLS_DIGIT;
    end else begin
      item_new.cls = CLS_OTHER;
    end
  end

  assign in_ready_o = (count_q != CntW'(QDepth));
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_valid_o & q_ready_i;

  always_comb begin
    wr_ptr_d = push ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

// ----- rtl/ctfp_back.sv -----
// back end: line state, tag match, number accumulation and the result register
module ctfp_back
  import ctfp_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  front_item_t           q_item_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [KindW-1:0]      res_kind_o,
  output logic                  res_neg_o,
  output logic [VALUE_BITS-1:0] res_mag_o
);

  localparam int unsigned ProdW = VALUE_BITS + 4;
  localparam logic [ProdW-1:0] Cap = ProdW'(1) << (VALUE_BITS - 1);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_DONE
  } num_phase_e;

  logic                  in_tag_q, in_tag_d;
  logic                  in_val_q, in_val_d;
  logic [ByteW-1:0]      letters_q [3];
  logic [ByteW-1:0]      letters_d [3];
  logic [2:0]            tag_cnt_q, tag_cnt_d;
  num_phase_e            phase_q, phase_d;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;

  logic                  res_valid_q, res_valid_d;
  logic [KindW-1:0]      res_kind_q;
  logic                  res_neg_q;
  logic [VALUE_BITS-1:0] res_mag_q;

  logic                  pop, open_line, close_line, matched;
  logic [KindW-1:0]      kind;
  logic [ProdW-1:0]      prod;
  logic [VALUE_BITS-1:0] mag_digit;

  // times ten plus digit, saturated at 2^(VALUE_BITS-1)
  always_comb begin
    prod = ProdW'({mag_q, 3'b000}) + ProdW'({mag_q, 1'b0}) + ProdW'(q_item_i.data[3:0]);
    mag_digit = (prod > Cap) ? VALUE_BITS'(Cap) : prod[VALUE_BITS-1:0];
  end

  // state after the byte, before any line close
  always_comb begin
    in_tag_d  = in_tag_q;
    in_val_d  = in_val_q;
    letters_d = letters_q;
    tag_cnt_d = tag_cnt_q;
    phase_d   = phase_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    case (q_item_i.cls)
      CLS_CR: begin
      end
      CLS_LF: begin
        in_val_d = 1'b0;
        in_tag_d = 1'b1;
      end
      CLS_TAB: begin
        in_tag_d = 1'b0;
        in_val_d = 1'b1;
      end
      default: begin
        if (in_tag_q) begin
          if (tag_cnt_q < 3'd3) begin
            letters_d[tag_cnt_q[1:0]] = q_item_i.data;
          end
          if (tag_cnt_q < 3'd4) begin
            tag_cnt_d = tag_cnt_q + 3'd1;
          end
        end else if (in_val_q) begin
          case (phase_q)
            PH_LEAD: begin
              case (q_item_i.cls)
                CLS_SPACE: begin
                end
                CLS_PLUS: begin
                  phase_d = PH_DIGITS;
                end
                CLS_MINUS: begin
                  neg_d   = 1'b1;
                  phase_d = PH_DIGITS;
                end
                CLS_DIGIT: begin
                  mag_d   = mag_digit;
                  phase_d = PH_DIGITS;
                end
                default: begin
                  phase_d = PH_DONE;
                end
              endcase
            end
            PH_DIGITS: begin
              if (q_item_i.cls == CLS_DIGIT) begin
                mag_d = mag_digit;
              end else begin
                phase_d = PH_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
    endcase
  end

  always_comb begin
    kind    = KindPower;
    matched = 1'b0;
    if (tag_cnt_d == 3'd1 && letters_d[0] == CharP) begin
      kind    = KindPower;
      matched = 1'b1;
    end else if (tag_cnt_d == 3'd1 && letters_d[0] == CharV) begin
      kind    = KindVoltage;
      matched = 1'b1;
    end else if (tag_cnt_d == 3'd3 && letters_d[0] == CharE && letters_d[1] == CharR
                 && letters_d[2] == CharR) begin
      kind    = KindError;
      matched = 1'b1;
    end else if (tag_cnt_d == 3'd2 && letters_d[0] == CharC && letters_d[1] == CharS) begin
      kind    = KindState;
      matched = 1'b1;
    end
  end

  assign q_ready_o  = !res_valid_q || res_ready_i;
  assign pop        = q_valid_i && q_ready_o;
  assign open_line  = in_tag_d || in_val_d;
  assign close_line = open_line && (q_item_i.cls == CLS_CR || q_item_i.last);

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
    if (pop && close_line && matched) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tag_q     <= 1'b0;
      in_val_q     <= 1'b0;
      letters_q[0] <= '0;
      letters_q[1] <= '0;
      letters_q[2] <= '0;
      tag_cnt_q    <= '0;
      phase_q      <= PH_LEAD;
      neg_q        <= 1'b0;
      mag_q        <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (pop) begin
        if (close_line || q_item_i.last) begin
          in_tag_q     <= 1'b0;
          in_val_q     <= 1'b0;
          letters_q[0] <= '0;
          letters_q[1] <= '0;
          letters_q[2] <= '0;
          tag_cnt_q    <= '0;
          phase_q      <= PH_LEAD;
          neg_q        <= 1'b0;
          mag_q        <= '0;
        end else begin
          in_tag_q  <= in_tag_d;
          in_val_q  <= in_val_d;
          letters_q <= letters_d;
          tag_cnt_q <= tag_cnt_d;
          phase_q   <= phase_d;
          neg_q     <= neg_d;
          mag_q     <= mag_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && close_line && matched) begin
      res_kind_q <= kind;
      res_neg_q  <= neg_d;
      res_mag_q  <= mag_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_kind_o  = res_kind_q;
  assign res_neg_o   = res_neg_q;
  assign res_mag_o   = res_mag_q;

endmodule

// ----- rtl/ctfp_out.sv -----
// output stage: signs and clamps the magnitude and holds the result for the receiver
module ctfp_out
  import ctfp_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  res_valid_i,
  output logic                  res_ready_o,
  input  logic [KindW-1:0]      res_kind_i,
  input  logic                  res_neg_i,
  input  logic [VALUE_BITS-1:0] res_mag_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [KindW-1:0]      out_kind_o,
  output logic [OutW-1:0]       out_value_o
);

  localparam logic [VALUE_BITS-1:0] PosMax = {1'b0, {(VALUE_BITS - 1){1'b1}}};

  logic                         out_valid_q;
  logic [KindW-1:0]             out_kind_q;
  logic [OutW-1:0]              out_value_q;
  logic signed [VALUE_BITS-1:0] sval;
  logic                         load;

  // magnitude never exceeds 2^(VALUE_BITS-1), so the top bit marks saturation
  always_comb begin
    if (res_neg_i) begin
      sval = $signed(VALUE_BITS'(0) - res_mag_i);
    end else if (res_mag_i[VALUE_BITS-1]) begin
      sval = $signed(PosMax);
    end else begin
      sval = $signed(res_mag_i);
    end
  end

  assign res_ready_o = !out_valid_q || out_ready_i;
  assign load        = res_valid_i && res_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q  <= res_kind_i;
      out_value_q <= OutW'(sval);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_value_q;

endmodule

// ----- rtl/charger_text_field_parser_unit.sv -----
// top level of the charger text field parser
//
// input stream: one text byte per request on s_axis, tlast marks the final
// byte of a buffer; an open line is then reported as if closed and all line
// state returns to its reset value
// output stream: one request on m_axis per line whose tag is P, V, ERR or CS,
// closed by a carriage return or by the end of a buffer; tuser holds the
// field kind, tdata the signed value saturated to VALUE_BITS bits
// throughput: one byte per cycle, with no gap between bytes, while no result waits at a stalled receiver
// result path: the result of a closing byte passes the byte queue, the back
// end result register and the output register before it is valid
// reset: asynchronous, clears the queue, the line state and the valid bits
// of both result registers; s_axis_tready is high right after reset
// receiver stall: the output register holds its request; one result and two
// queued bytes are still taken, then s_axis_tready drops
module charger_text_field_parser_unit
  import ctfp_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // byte stream in
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] data_byte
  input  logic             s_axis_tlast,   // last_in_buffer
  // field results out
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OutW-1:0]  m_axis_tdata,   // [31:0] field_value
  output logic [KindW-1:0] m_axis_tuser    // [1:0] field_kind
);

  // front end to back end: classified byte queue
  logic                  q_valid;
  logic                  q_ready;
  front_item_t           q_item;

  // back end to output stage: kind, sign and saturated magnitude of a line
  logic                  res_valid;
  logic                  res_ready;
  logic [KindW-1:0]      res_kind;
  logic                  res_neg;
  logic [VALUE_BITS-1:0] res_mag;

  ctfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  // line state machine, runs one queued byte per cycle unless its result waits
  ctfp_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_kind_o  (res_kind),
    .res_neg_o   (res_neg),
    .res_mag_o   (res_mag)
  );

  // sign and clamp, then the registered output request
  ctfp_out #(
    .VALUE_BITS (VALUE_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_kind_i  (res_kind),
    .res_neg_i   (res_neg),
    .res_mag_i   (res_mag),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_value_o (m_axis_tdata)
  );

endmodule

// ----- rtl/ctfp_checker.sv -----
// port checker for the charger text field parser, bound to the top level
`include "assert_macros.svh"

module ctfp_checker
  import ctfp_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OutW-1:0]  m_axis_tdata,
  input logic [KindW-1:0] m_axis_tuser
);

  property p_ready_after_reset;
    $rose(rst_ni) |-> s_axis_tready;
  endproperty

  property p_out_hold;
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser);
  endproperty

  property p_backpressure_source;
    !s_axis_tready |-> m_axis_tvalid;
  endproperty

  // no result request while reset is held
  `CTFP_ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid, "result during reset")

  // empty queue right after reset
  `CTFP_ASSERT_ALWAYS(a_ready_after_reset, clk_i, p_ready_after_reset, "not ready after reset")

  // a stalled result request keeps its payload
  `CTFP_ASSERT(a_out_hold, clk_i, rst_ni, p_out_hold, "stalled result changed")

  // input back pressure only comes from a result held at the output
  `CTFP_ASSERT(a_backpressure_source, clk_i, rst_ni, p_backpressure_source, "stall without result")

endmodule

bind charger_text_field_parser_unit ctfp_checker u_ctfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
